// File: hw/rtl/assert_macros.svh
// Assertion helper macros for the value noise core.
// Self-contained; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// cond holds in a cycle -> prop starts in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> prop) \
		else $error("assertion failed");
// cond holds in a cycle -> prop starts in the next cycle
`define ASSERT_IMPLY_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> prop) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define ASSERT_IMPLY_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// File: hw/rtl/fvn_pkg.sv
// Shared constants, hash coefficients and the inter-cell bus type of the value noise core.
// No dependencies; used by every RTL file of the block.
package fvn_pkg;

	// number of octave cells in the chain
	localparam int OCTAVE_COUNT = 4;

	// coordinate and scale formats
	localparam int COORD_W = 32;
	localparam int FREQ_W = 24;
	localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd65536;
	localparam int PROD_W = COORD_W + FREQ_W + 1;
	localparam int WRAP_W = 64;
	localparam int CELL_W = 32;
	localparam int FRAC_W = 16;
	localparam int FRAC_LSB = 16;

	// smoothstep and blend formats
	localparam int SMOOTH_W = FRAC_W + 2;
	localparam logic [SMOOTH_W-1:0] SMOOTH_K = 18'd196608;
	localparam int WEIGHT_W = FRAC_W + 1;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
	localparam int VALUE_W = 24;
	localparam int BLEND_W = VALUE_W + FRAC_W;

	// lattice hash
	localparam logic [CELL_W-1:0] HASH_MUL_X = 32'd374761393;
	localparam logic [CELL_W-1:0] HASH_MUL_Z = 32'd668265263;
	localparam logic [CELL_W-1:0] HASH_SEED_TERM = 32'(64'd1337 * 64'd982451653);
	localparam logic [CELL_W-1:0] HASH_MIX = 32'd1274126177;
	localparam int CORNER_COUNT = 4;
	localparam int CORNER_00 = 0;
	localparam int CORNER_10 = 1;
	localparam int CORNER_01 = 2;
	localparam int CORNER_11 = 3;

	// accumulation and normalization
	localparam int OUT_W = 16;
	localparam int SUM_W = VALUE_W + OCTAVE_COUNT;
	localparam int ACC_DROP = VALUE_W - OUT_W;
	localparam int Y_W = SUM_W - ACC_DROP;
	localparam int NORM = (1 << OCTAVE_COUNT) - 1;
	localparam int RECIP_SHIFT = Y_W + 1;
	localparam int RECIP_W = RECIP_SHIFT - OCTAVE_COUNT + 2;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / NORM);

	// pipeline depths
	localparam int CELL_LAT = 7;
	localparam int NORM_LAT = 2;
	localparam int TOTAL_LAT = 1 + CELL_LAT * OCTAVE_COUNT + NORM_LAT;

	// bus handed from one octave cell to the next
	typedef struct packed {
		logic              vld;
		logic [WRAP_W-1:0] px;
		logic [WRAP_W-1:0] pz;
		logic [SUM_W-1:0]  acc;
	} cell_bus_t;

endpackage

// File: hw/rtl/fractal_value_noise_2d_core.sv
// Top level of the 2D fractal value noise core: frequency register, scale stage,
// octave cell chain and normalizer. Depends on fvn_pkg, fvn_cell, fvn_norm, assert_macros.svh.
//
// Takes one coordinate pair per clock: busy stays low, so start may be held high every
// cycle. Each accepted item yields exactly one noise_value, flagged by done for a single
// cycle, after it has passed one scale stage, the chain of octave cells of seven pipeline
// stages each, and two normalizer stages. Results come out in input order and cannot be
// held off: the receiver must take done/noise_value in the cycle they appear. Write
// frequency only while no item is in flight.
`include "assert_macros.svh"

module fractal_value_noise_2d_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [fvn_pkg::FREQ_W-1:0]          cfg_wr_data,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [fvn_pkg::COORD_W-1:0]  x_coord,
	input  logic signed [fvn_pkg::COORD_W-1:0]  z_coord,
	output logic                                done,
	output logic signed [fvn_pkg::OUT_W-1:0]    noise_value
);

	logic [fvn_pkg::FREQ_W-1:0]        freq_q;
	logic                              vld_s1;
	logic signed [fvn_pkg::PROD_W-1:0] px_s1, pz_s1;
	fvn_pkg::cell_bus_t                chain [fvn_pkg::OCTAVE_COUNT+1];
	logic [fvn_pkg::OUT_W-1:0]         noise;

	// the pipeline takes a new item every cycle
	assign busy = 1'b0;

	// hold the frequency register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= fvn_pkg::FREQ_RESET;
		end else if (cfg_wr_en) begin
			freq_q <= cfg_wr_data;
		end
	end

	// track the scale stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	// scale both coordinates by the frequency
	always_ff @(posedge clk) begin
		px_s1 <= fvn_pkg::PROD_W'(x_coord) * fvn_pkg::PROD_W'($signed({1'b0, freq_q}));
		pz_s1 <= fvn_pkg::PROD_W'(z_coord) * fvn_pkg::PROD_W'($signed({1'b0, freq_q}));
	end

	// head of the chain: sign-extended product, empty sum
	assign chain[0].vld = vld_s1;
	assign chain[0].px = {{(fvn_pkg::WRAP_W-fvn_pkg::PROD_W){px_s1[fvn_pkg::PROD_W-1]}}, px_s1};
	assign chain[0].pz = {{(fvn_pkg::WRAP_W-fvn_pkg::PROD_W){pz_s1[fvn_pkg::PROD_W-1]}}, pz_s1};
	assign chain[0].acc = '0;

	// one cell per octave
	for (genvar g = 0; g < fvn_pkg::OCTAVE_COUNT; g++) begin : g_octave
		fvn_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.up     (chain[g]),
			.down   (chain[g+1])
		);
	end

	// divide by the total weight
	fvn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (chain[fvn_pkg::OCTAVE_COUNT].vld),
		.acc    (chain[fvn_pkg::OCTAVE_COUNT].acc),
		.done   (done),
		.noise  (noise)
	);

	assign noise_value = $signed(noise);

	// every transfer yields a result at the end of the pipeline, and every result stems from a transfer
	`ASSERT_IMPLY(a_item_gives_result, clk, arst_n, start && !busy, ##(fvn_pkg::TOTAL_LAT) done)
	`ASSERT_IMPLY(a_result_has_item, clk, arst_n, done, $past(start && !busy, fvn_pkg::TOTAL_LAT))
	`ASSERT_IMPLY_NEXT(a_freq_write, clk, arst_n, cfg_wr_en, freq_q == $past(cfg_wr_data))

endmodule

// File: hw/rtl/fvn_cell.sv
// One octave cell: smoothstep, four-corner lattice hash, bilinear blend, accumulate.
// Depends on fvn_pkg; instantiated once per octave by the top level.
module fvn_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  fvn_pkg::cell_bus_t up,
	output fvn_pkg::cell_bus_t down
);

	typedef struct packed {
		logic [fvn_pkg::WRAP_W-1:0] px;
		logic [fvn_pkg::WRAP_W-1:0] pz;
	} coord_t;

	// stage 1 inputs
	logic [fvn_pkg::CELL_W-1:0] cell_x, cell_z;
	logic [fvn_pkg::FRAC_W-1:0] frac_x, frac_z;

	// stage registers
	logic [2*fvn_pkg::FRAC_W-1:0]   tx2_s1, tz2_s1;
	logic [fvn_pkg::SMOOTH_W-1:0]   kx_s1, kz_s1;
	logic [fvn_pkg::CELL_W-1:0]     hx_s1, hz_s1;
	logic [fvn_pkg::FRAC_W-1:0]     wx_s2, wz_s2, wx_s3, wz_s3, wz_s4, wz_s5;
	logic [fvn_pkg::CELL_W-1:0]     hash_s2 [fvn_pkg::CORNER_COUNT];
	logic [fvn_pkg::CELL_W-1:0]     mix_s3 [fvn_pkg::CORNER_COUNT];
	logic [fvn_pkg::BLEND_W-1:0]    part_s4 [fvn_pkg::CORNER_COUNT];
	logic [fvn_pkg::VALUE_W-1:0]    row_s5 [2];
	logic [fvn_pkg::BLEND_W-1:0]    part_s6 [2];
	logic [fvn_pkg::SUM_W-1:0]      acc_s7;

	// delay lines for the values that only ride along
	logic [fvn_pkg::CELL_LAT-1:0]   vld_pipe_q;
	coord_t                         coord_pipe_q [fvn_pkg::CELL_LAT];
	logic [fvn_pkg::SUM_W-1:0]      acc_pipe_q [fvn_pkg::CELL_LAT-1];

	// combinational values
	logic [2*fvn_pkg::FRAC_W+fvn_pkg::SMOOTH_W-1:0] sx_prod, sz_prod;
	logic [fvn_pkg::CELL_W-1:0]     hash_base;
	logic [fvn_pkg::VALUE_W-1:0]    corner_val [fvn_pkg::CORNER_COUNT];
	logic [fvn_pkg::WEIGHT_W-1:0]   wx_inv, wz_inv;
	logic [fvn_pkg::BLEND_W-1:0]    row_sum [2];
	logic [fvn_pkg::BLEND_W-1:0]    col_sum;

	// split the scaled coordinate into cell index and fraction
	assign cell_x = up.px[fvn_pkg::WRAP_W-1 -: fvn_pkg::CELL_W];
	assign cell_z = up.pz[fvn_pkg::WRAP_W-1 -: fvn_pkg::CELL_W];
	assign frac_x = up.px[fvn_pkg::FRAC_LSB +: fvn_pkg::FRAC_W];
	assign frac_z = up.pz[fvn_pkg::FRAC_LSB +: fvn_pkg::FRAC_W];

	// smoothstep second product, hash base sum
	assign sx_prod = {{fvn_pkg::SMOOTH_W{1'b0}}, tx2_s1} * {{2*fvn_pkg::FRAC_W{1'b0}}, kx_s1};
	assign sz_prod = {{fvn_pkg::SMOOTH_W{1'b0}}, tz2_s1} * {{2*fvn_pkg::FRAC_W{1'b0}}, kz_s1};
	assign hash_base = hx_s1 + hz_s1 + fvn_pkg::HASH_SEED_TERM;

	// finish the hash, form the inverse blend weights and add the weighted products
	always_comb begin
		for (int i = 0; i < fvn_pkg::CORNER_COUNT; i++) begin
			corner_val[i] = fvn_pkg::VALUE_W'(mix_s3[i] ^ (mix_s3[i] >> 16));
		end
		wx_inv = fvn_pkg::WEIGHT_ONE - {1'b0, wx_s3};
		wz_inv = fvn_pkg::WEIGHT_ONE - {1'b0, wz_s5};
		row_sum[0] = part_s4[fvn_pkg::CORNER_00] + part_s4[fvn_pkg::CORNER_10];
		row_sum[1] = part_s4[fvn_pkg::CORNER_01] + part_s4[fvn_pkg::CORNER_11];
		col_sum = part_s6[0] + part_s6[1];
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_pipe_q <= '0;
		end else begin
			vld_pipe_q <= {vld_pipe_q[fvn_pkg::CELL_LAT-2:0], up.vld};
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		// stage 1: square fractions, form the 3 - 2t factors, hash partial products, double the coordinate
		tx2_s1 <= {{fvn_pkg::FRAC_W{1'b0}}, frac_x} * {{fvn_pkg::FRAC_W{1'b0}}, frac_x};
		tz2_s1 <= {{fvn_pkg::FRAC_W{1'b0}}, frac_z} * {{fvn_pkg::FRAC_W{1'b0}}, frac_z};
		kx_s1 <= fvn_pkg::SMOOTH_K - {1'b0, frac_x, 1'b0};
		kz_s1 <= fvn_pkg::SMOOTH_K - {1'b0, frac_z, 1'b0};
		hx_s1 <= cell_x * fvn_pkg::HASH_MUL_X;
		hz_s1 <= cell_z * fvn_pkg::HASH_MUL_Z;
		coord_pipe_q[0] <= '{px: {up.px[fvn_pkg::WRAP_W-2:0], 1'b0},
			pz: {up.pz[fvn_pkg::WRAP_W-2:0], 1'b0}};
		acc_pipe_q[0] <= up.acc;
		for (int i = 1; i < fvn_pkg::CELL_LAT; i++) begin
			coord_pipe_q[i] <= coord_pipe_q[i-1];
		end
		for (int i = 1; i < fvn_pkg::CELL_LAT - 1; i++) begin
			acc_pipe_q[i] <= acc_pipe_q[i-1];
		end

		// stage 2: smoothstep weights, corner hash sums
		wx_s2 <= sx_prod[3*fvn_pkg::FRAC_W-1 -: fvn_pkg::FRAC_W];
		wz_s2 <= sz_prod[3*fvn_pkg::FRAC_W-1 -: fvn_pkg::FRAC_W];
		hash_s2[fvn_pkg::CORNER_00] <= hash_base;
		hash_s2[fvn_pkg::CORNER_10] <= hash_base + fvn_pkg::HASH_MUL_X;
		hash_s2[fvn_pkg::CORNER_01] <= hash_base + fvn_pkg::HASH_MUL_Z;
		hash_s2[fvn_pkg::CORNER_11] <= hash_base + fvn_pkg::HASH_MUL_X
			+ fvn_pkg::HASH_MUL_Z;

		// stage 3: hash mixing multiply
		wx_s3 <= wx_s2;
		wz_s3 <= wz_s2;
		for (int i = 0; i < fvn_pkg::CORNER_COUNT; i++) begin
			mix_s3[i] <= (hash_s2[i] ^ (hash_s2[i] >> 13)) * fvn_pkg::HASH_MIX;
		end

		// stage 4: weighted corner products along x
		wz_s4 <= wz_s3;
		part_s4[fvn_pkg::CORNER_00] <= fvn_pkg::BLEND_W'(corner_val[fvn_pkg::CORNER_00])
			* fvn_pkg::BLEND_W'(wx_inv);
		part_s4[fvn_pkg::CORNER_10] <= fvn_pkg::BLEND_W'(corner_val[fvn_pkg::CORNER_10])
			* fvn_pkg::BLEND_W'(wx_s3);
		part_s4[fvn_pkg::CORNER_01] <= fvn_pkg::BLEND_W'(corner_val[fvn_pkg::CORNER_01])
			* fvn_pkg::BLEND_W'(wx_inv);
		part_s4[fvn_pkg::CORNER_11] <= fvn_pkg::BLEND_W'(corner_val[fvn_pkg::CORNER_11])
			* fvn_pkg::BLEND_W'(wx_s3);

		// stage 5: row values
		wz_s5 <= wz_s4;
		row_s5[0] <= row_sum[0][fvn_pkg::BLEND_W-1:fvn_pkg::FRAC_W];
		row_s5[1] <= row_sum[1][fvn_pkg::BLEND_W-1:fvn_pkg::FRAC_W];

		// stage 6: weighted row products along z
		part_s6[0] <= fvn_pkg::BLEND_W'(row_s5[0]) * fvn_pkg::BLEND_W'(wz_inv);
		part_s6[1] <= fvn_pkg::BLEND_W'(row_s5[1]) * fvn_pkg::BLEND_W'(wz_s5);

		// stage 7: octave value folded into the running sum, earlier octaves doubled
		acc_s7 <= {acc_pipe_q[fvn_pkg::CELL_LAT-2][fvn_pkg::SUM_W-2:0], 1'b0}
			+ fvn_pkg::SUM_W'(col_sum[fvn_pkg::BLEND_W-1:fvn_pkg::FRAC_W]);
	end

	// hand off to the next cell
	assign down.vld = vld_pipe_q[fvn_pkg::CELL_LAT-1];
	assign down.px = coord_pipe_q[fvn_pkg::CELL_LAT-1].px;
	assign down.pz = coord_pipe_q[fvn_pkg::CELL_LAT-1].pz;
	assign down.acc = acc_s7;

endmodule

// File: hw/rtl/fvn_norm.sv
// Normalizer: divides the octave sum by the total weight and maps it to signed Q1.15.
// Depends on fvn_pkg; the division uses a constant reciprocal and one correction step.
module fvn_norm (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic [fvn_pkg::SUM_W-1:0]   acc,
	output logic                        done,
	output logic [fvn_pkg::OUT_W-1:0]   noise
);

	logic                               vld_s1, vld_s2;
	logic [fvn_pkg::Y_W-1:0]            y_s1;
	logic [fvn_pkg::Y_W+fvn_pkg::RECIP_W-1:0] est_s1;
	logic [fvn_pkg::OUT_W-1:0]          noise_s2;

	logic [fvn_pkg::Y_W-1:0]            y_in;
	logic [fvn_pkg::OUT_W-1:0]          q_est, q_fix;
	logic [fvn_pkg::Y_W-1:0]            q_times_norm, rem;

	// drop the fraction below the output resolution
	assign y_in = acc[fvn_pkg::SUM_W-1:fvn_pkg::ACC_DROP];

	// estimate is exact or one low; fix from the remainder
	always_comb begin
		q_est = est_s1[fvn_pkg::RECIP_SHIFT +: fvn_pkg::OUT_W];
		q_times_norm = {q_est, {fvn_pkg::OCTAVE_COUNT{1'b0}}} - fvn_pkg::Y_W'(q_est);
		rem = y_s1 - q_times_norm;
		q_fix = q_est + fvn_pkg::OUT_W'(rem >= fvn_pkg::Y_W'(fvn_pkg::NORM));
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// reciprocal multiply, then corrected quotient with the sign bit flipped
	always_ff @(posedge clk) begin
		y_s1 <= y_in;
		est_s1 <= {{fvn_pkg::RECIP_W{1'b0}}, y_in} * {{fvn_pkg::Y_W{1'b0}}, fvn_pkg::RECIP};
		noise_s2 <= {~q_fix[fvn_pkg::OUT_W-1], q_fix[fvn_pkg::OUT_W-2:0]};
	end

	assign done = vld_s2;
	assign noise = noise_s2;

endmodule
